[hdl/sorted_priority_queue_macros.svh]
// assertion macros shared by the sorted priority queue rtl
// depends on nothing; taken in by `include where assertions are written
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sorted priority queue check failed");

// next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sorted priority queue check failed");

`endif

[hdl/spq_pkg.sv]
// types and codes of the sorted priority queue
// depends on nothing; used by every module of the block but spq_scan
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned ITEM_W  = 32;
	localparam int unsigned COUNT_W = 5;

	// key given to an entry placed by append
	localparam logic signed [KEY_W-1:0] APPEND_KEY = 32'sd1;

	typedef enum logic [1:0] {
		CMD_APPEND      = 2'd0,
		CMD_INSERT      = 2'd1,
		CMD_REMOVE_HEAD = 2'd2,
		CMD_REMOVE_KEY  = 2'd3
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_SELECT,
		ST_APPLY
	} spq_state_t;

	// what a cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} spq_cell_op_t;

	typedef struct packed {
		logic                     valid;
		logic signed [KEY_W-1:0]  key;
		logic        [ITEM_W-1:0] item;
	} spq_entry_t;

	typedef struct packed {
		spq_cmd_t                 cmd;
		logic signed [KEY_W-1:0]  key_in;
		logic        [ITEM_W-1:0] item_in;
	} spq_cmd_data_t;

	typedef struct packed {
		logic        [ITEM_W-1:0]  item_out;
		logic signed [KEY_W-1:0]   key_out;
		logic                      found;
		logic                      overflow;
		logic        [COUNT_W-1:0] entry_count;
	} spq_res_data_t;

	// compare flags a cell reports against the probe key
	typedef struct packed {
		logic gt;
		logic eq;
	} spq_cell_flags_t;

endpackage

[hdl/spq_cell.sv]
// one storage cell of the queue chain: holds an entry, compares it with the probe key
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_pkg::spq_cell_op_t   op,
	input  spq_pkg::spq_entry_t     new_entry,
	input  spq_pkg::spq_entry_t     left_entry,
	input  spq_pkg::spq_entry_t     right_entry,
	input  logic signed [31:0]      probe_key,
	output spq_pkg::spq_entry_t     entry,
	output spq_pkg::spq_cell_flags_t flags
);
	import spq_pkg::*;

	logic                     valid_q;
	logic signed [KEY_W-1:0]  key_q;
	logic        [ITEM_W-1:0] item_q;
	spq_entry_t               next_entry;

	always_comb begin
		unique case (op)
			CELL_HOLD:       next_entry = entry;
			CELL_LOAD:       next_entry = new_entry;
			CELL_FROM_LEFT:  next_entry = left_entry;
			CELL_FROM_RIGHT: next_entry = right_entry;
			default:         next_entry = entry;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= next_entry.valid;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		key_q  <= next_entry.key;
		item_q <= next_entry.item;
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.item  = item_q;

	assign flags.gt = valid_q && ($signed(probe_key) < $signed(key_q));
	assign flags.eq = valid_q && (probe_key == key_q);

endmodule

[hdl/spq_scan.sv]
// log-depth prefix or across the cell row: marks every cell at or after the first hit
// depends on nothing
`timescale 1ns / 1ps

module spq_scan #(
	parameter int unsigned WIDTH = 16
) (
	input  logic [WIDTH-1:0] hit,
	output logic [WIDTH-1:0] from_first
);
	localparam int unsigned LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] lvl [0:LEVELS];

	assign lvl[0] = hit;

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign from_first = lvl[LEVELS];

endmodule

[hdl/sorted_priority_queue.sv]
// sorted priority queue: chain of CAPACITY cells, one entry each, shifting on insert/remove
// the result is registered once the compare, scan and apply steps that follow the command transaction are done
// a new command is taken only while idle, once the last one has gone through compare -> scan -> shift
// a full result register stalls the apply step until the result transaction completes
// reset: arst_n clears all cell valid bits, the fill count and the result valid at once
`timescale 1ns / 1ps

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  spq_pkg::spq_cmd_data_t cmd_data,
	output logic                   res_valid,
	input  logic                   res_ready,
	output spq_pkg::spq_res_data_t res_data
);
	import spq_pkg::*;

	// fill count must hold CAPACITY itself
	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

	// control
	spq_state_t state_q, state_d;
	logic       cmd_fire;
	logic       apply_fire;

	// latched command
	spq_cmd_t                 cmd_q;
	logic signed [KEY_W-1:0]  key_q;
	logic        [ITEM_W-1:0] item_q;

	// fill count
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;

	// per-cell view
	spq_entry_t      entries   [CAPACITY];
	spq_cell_flags_t flags     [CAPACITY];
	spq_cell_op_t    cell_op   [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] hit_s1;
	logic [CAPACITY-1:0] from_first;
	logic [CAPACITY-1:0] from_first_s2;
	logic [CAPACITY-1:0] first_cell;
	spq_entry_t          new_entry;
	spq_entry_t          picked;

	// command classes
	logic is_insert;
	logic is_remove;
	logic full;
	logic found;
	logic do_change;

	// result register
	logic          res_valid_q;
	spq_res_data_t res_q;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (cmd_valid) state_d = ST_COMPARE;
			ST_COMPARE: state_d = ST_SELECT;
			ST_SELECT:  state_d = ST_APPLY;
			ST_APPLY:   if (!res_valid_q || res_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready  = (state_q == ST_IDLE);
		apply_fire = (state_q == ST_APPLY) && (!res_valid_q || res_ready);
	end

	assign cmd_fire = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command fields are held for the whole sequence
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q  <= cmd_data.cmd;
			key_q  <= cmd_data.key_in;
			item_q <= cmd_data.item_in;
		end
	end

	// ------------------------------------------------------------------
	// cell chain
	// ------------------------------------------------------------------

	assign new_entry.valid = 1'b1;
	assign new_entry.key   = (cmd_q == CMD_APPEND) ? APPEND_KEY : key_q;
	assign new_entry.item  = item_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_entry_t left_e;
		spq_entry_t right_e;

		// cell 0 never takes from the left, the last cell empties from the right
		if (i == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_left
			assign left_e = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_right
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (cell_op[i]),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.probe_key   (key_q),
			.entry       (entries[i]),
			.flags       (flags[i])
		);

		assign valid_vec[i] = entries[i].valid;
	end

	// ------------------------------------------------------------------
	// compare step: every cell flags where the command lands
	// ------------------------------------------------------------------

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			unique case (cmd_q)
				// tail is the first empty cell, valid cells form a prefix
				CMD_APPEND:      hit[i] = !valid_vec[i];
				// first strictly greater key, else the tail
				CMD_INSERT:      hit[i] = flags[i].gt || !valid_vec[i];
				CMD_REMOVE_HEAD: hit[i] = (i == 0) && valid_vec[i];
				CMD_REMOVE_KEY:  hit[i] = flags[i].eq;
				default:         hit[i] = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMPARE) begin
			hit_s1 <= hit;
		end
	end

	// ------------------------------------------------------------------
	// select step: prefix scan turns hits into a from-first mask
	// ------------------------------------------------------------------

	spq_scan #(
		.WIDTH (CAPACITY)
	) u_scan (
		.hit        (hit_s1),
		.from_first (from_first)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_SELECT) begin
			from_first_s2 <= from_first;
		end
	end

	// ------------------------------------------------------------------
	// apply step: shift cells, pick the removed entry, count
	// ------------------------------------------------------------------

	assign first_cell = from_first_s2 & ~(from_first_s2 << 1);

	assign is_insert = (cmd_q == CMD_APPEND) || (cmd_q == CMD_INSERT);
	assign is_remove = !is_insert;
	assign full      = (fill_q == FILL_W'(CAPACITY));
	// any hit leaves the top mask bit set
	assign found     = is_remove && from_first_s2[CAPACITY-1];
	assign do_change = apply_fire && (is_insert ? !full : found);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = CELL_HOLD;
			if (do_change) begin
				if (is_insert) begin
					if (first_cell[i]) begin
						cell_op[i] = CELL_LOAD;
					end else if (from_first_s2[i]) begin
						cell_op[i] = CELL_FROM_LEFT;
					end
				end else if (from_first_s2[i]) begin
					cell_op[i] = CELL_FROM_RIGHT;
				end
			end
		end
	end

	// one-hot and-or pick of the removed entry
	always_comb begin
		picked = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			picked = picked | (first_cell[i] ? entries[i] : '0);
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (do_change) begin
			if (is_insert) begin
				fill_d = fill_q + FILL_W'(1);
			end else begin
				fill_d = fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (apply_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			res_q.item_out    <= found ? picked.item : '0;
			res_q.key_out     <= found ? picked.key : '0;
			res_q.found       <= found;
			res_q.overflow    <= is_insert && full;
			// count reported modulo 32
			res_q.entry_count <= COUNT_W'(fill_d);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------

	// valid cells are exactly the fill count
	`SPQ_ASSERT_NOW(a_count_matches_cells, clk, arst_n, 1'b1, $countones(valid_vec) == fill_q)
	// valid cells form a prefix of the chain
	`SPQ_ASSERT_NOW(a_valid_prefix, clk, arst_n, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
	// an insert that fits lands in exactly one cell
	`SPQ_ASSERT_NOW(a_insert_one_cell, clk, arst_n, (state_q == ST_APPLY) && is_insert && !full, $onehot(first_cell))
	// a removal that hits shrinks the list by one
	`SPQ_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, apply_fire && found, fill_q == $past(fill_q) - FILL_W'(1))
	// every apply leaves a result waiting
	`SPQ_ASSERT_NEXT(a_apply_gives_result, clk, arst_n, apply_fire, res_valid_q)
	// a result never reports both a hit and a dropped insert
	`SPQ_ASSERT_NOW(a_found_excl_overflow, clk, arst_n, res_valid_q, !(res_q.found && res_q.overflow))

endmodule

[dv/sorted_priority_queue_test.sv]
// self-checking bench for the sorted priority queue: directed and random commands,
// a scoreboard that tracks the entry list, and random idling on both channels
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module sorted_priority_queue_test;

	import spq_pkg::*;

	localparam int unsigned CAPACITY    = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned SETTLE      = 8;

	// tracks the list contents and the results still owed by the block
	class spq_scoreboard;
		int unsigned             capacity;
		logic signed [KEY_W-1:0] list_keys[$];
		logic [ITEM_W-1:0]       list_items[$];
		spq_res_data_t           owed_results[$];
		int unsigned             errors;
		int unsigned             results_seen;

		function new(int unsigned cap);
			capacity     = cap;
			errors       = 0;
			results_seen = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at result %0d: %s", results_seen, msg);
			errors++;
		endtask

		// work out what one accepted command returns and apply it to the list
		function void note_command(spq_cmd_data_t c);
			spq_res_data_t r;
			int unsigned   pos;
			r   = '0;
			pos = 0;
			if (c.cmd == CMD_APPEND || c.cmd == CMD_INSERT) begin
				if (list_keys.size() >= capacity) begin
					r.overflow = 1'b1;
				end else if (c.cmd == CMD_APPEND) begin
					list_keys.push_back(APPEND_KEY);
					list_items.push_back(c.item_in);
				end else begin
					// stop at the first key strictly greater, even in an unordered list
					while (pos < list_keys.size() &&
							!($signed(c.key_in) < $signed(list_keys[pos])))
						pos++;
					list_keys.insert(pos, c.key_in);
					list_items.insert(pos, c.item_in);
				end
			end else if (c.cmd == CMD_REMOVE_HEAD) begin
				if (list_keys.size() != 0) begin
					r.item_out = list_items.pop_front();
					r.key_out  = list_keys.pop_front();
					r.found    = 1'b1;
				end
			end else begin
				while (pos < list_keys.size() && list_keys[pos] != c.key_in)
					pos++;
				if (pos < list_keys.size()) begin
					r.item_out = list_items[pos];
					r.key_out  = list_keys[pos];
					r.found    = 1'b1;
					list_keys.delete(pos);
					list_items.delete(pos);
				end
			end
			r.entry_count = COUNT_W'(list_keys.size());
			owed_results.push_back(r);
		endfunction

		task check_result(spq_res_data_t got);
			spq_res_data_t want;
			results_seen++;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed, item %h key %0d",
					got.item_out, got.key_out));
				return;
			end
			want = owed_results.pop_front();
			if (got.item_out !== want.item_out)
				report_mismatch($sformatf("item_out %h, want %h", got.item_out, want.item_out));
			if (got.key_out !== want.key_out)
				report_mismatch($sformatf("key_out %0d, want %0d", got.key_out, want.key_out));
			if (got.found !== want.found)
				report_mismatch($sformatf("found %b, want %b", got.found, want.found));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count %0d, want %0d",
					got.entry_count, want.entry_count));
		endtask

		task report_leftovers();
			if (owed_results.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_ready;
	spq_cmd_data_t cmd_data;
	logic          res_valid;
	logic          res_ready = 1'b0;
	spq_res_data_t res_data;

	spq_scoreboard sb;

	// idle odds in percent, changed per phase by the stimulus process
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;

	// long receiver hold-off: stimulus bumps the request count, the receiver counts the cycles
	int unsigned hold_requests = 0;
	int unsigned holds_done    = 0;
	int unsigned hold_left     = 0;

	int unsigned cycle_count = 0;

	sorted_priority_queue #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data (cmd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, plus the long hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left  <= HOLD_CYCLES;
			res_ready  <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// every result transaction goes to the scoreboard; values seen are the pre-edge ones
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res_data);
	end

	function automatic spq_cmd_data_t cmd_of(spq_cmd_t op, logic signed [KEY_W-1:0] k,
			logic [ITEM_W-1:0] it);
		spq_cmd_data_t c;
		c.cmd     = op;
		c.key_in  = k;
		c.item_in = it;
		return c;
	endfunction

	// keys cluster in a narrow band so equal keys and hits on remove are common
	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned roll;
		int unsigned held;
		roll = $urandom_range(99);
		held = sb.list_keys.size();
		if (roll < 20 && held != 0)
			return sb.list_keys[$urandom_range(held - 1)];
		if (roll < 65)
			return $signed($urandom_range(8)) - 32'sd4;
		if (roll < 75) begin
			case ($urandom_range(3))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7fff_ffff;
				2:       return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $signed($urandom());
	endfunction

	function automatic logic [ITEM_W-1:0] pick_item();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return '1;
		return $urandom();
	endfunction

	// fill bias leans toward inserts, otherwise toward removes, so the list
	// wanders between empty and full
	function automatic spq_cmd_data_t make_command(bit fill_bias);
		spq_cmd_data_t c;
		int unsigned   roll;
		int unsigned   held;
		roll      = $urandom_range(99);
		held      = sb.list_keys.size();
		c.item_in = pick_item();
		c.key_in  = pick_key();
		if (fill_bias) begin
			if (roll < 25)      c.cmd = CMD_APPEND;
			else if (roll < 75) c.cmd = CMD_INSERT;
			else if (roll < 85) c.cmd = CMD_REMOVE_HEAD;
			else                c.cmd = CMD_REMOVE_KEY;
		end else begin
			if (roll < 10)      c.cmd = CMD_APPEND;
			else if (roll < 25) c.cmd = CMD_INSERT;
			else if (roll < 65) c.cmd = CMD_REMOVE_HEAD;
			else                c.cmd = CMD_REMOVE_KEY;
		end
		// most key removes aim at a key that is held
		if (c.cmd == CMD_REMOVE_KEY && held != 0 && $urandom_range(99) < 70)
			c.key_in = sb.list_keys[$urandom_range(held - 1)];
		return c;
	endfunction

	// called at a rising edge; returns at the edge where the command transaction happens
	task automatic send_command(spq_cmd_data_t c);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		sb.note_command(c);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned left;
		int unsigned burst;
		bit          fill_bias;
		left = count;
		while (left != 0) begin
			burst = $urandom_range(30, 8);
			if (burst > left)
				burst = left;
			fill_bias = 1'($urandom_range(1));
			repeat (burst)
				send_command(make_command(fill_bias));
			left -= burst;
		end
	endtask

	// sender stops offering until every owed result has come back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed_results.size() != 0);
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		sb        = new(CAPACITY);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender idles now and then, receiver mostly stalls
		src_idle_pct  = 38;
		sink_idle_pct = 72;

		// removes on an empty list
		send_command(cmd_of(CMD_REMOVE_HEAD, 32'sd0, '0));
		send_command(cmd_of(CMD_REMOVE_KEY, 32'sd0, '0));
		// appends carry the fixed key, payload extremes
		send_command(cmd_of(CMD_APPEND, 32'sd77, '0));
		send_command(cmd_of(CMD_APPEND, -32'sd77, '1));
		// key extremes and a key equal to the appended ones
		send_command(cmd_of(CMD_INSERT, 32'sh8000_0000, 32'h0000_0001));
		send_command(cmd_of(CMD_INSERT, 32'sh7fff_ffff, 32'h0000_0002));
		send_command(cmd_of(CMD_INSERT, 32'sd0, 32'h5555_5555));
		send_command(cmd_of(CMD_INSERT, -32'sd1, 32'haaaa_aaaa));
		send_command(cmd_of(CMD_INSERT, 32'sd1, 32'h0000_0003));
		// append after the largest key leaves the list out of order
		send_command(cmd_of(CMD_APPEND, 32'sd0, 32'h0000_0004));
		send_command(cmd_of(CMD_INSERT, 32'sd5, 32'h0000_0005));
		send_command(cmd_of(CMD_INSERT, 32'sd2, 32'h0000_0006));
		// remove by key: first match, a miss, both extremes
		send_command(cmd_of(CMD_REMOVE_KEY, 32'sd1, '0));
		send_command(cmd_of(CMD_REMOVE_KEY, 32'sd12345, '0));
		send_command(cmd_of(CMD_REMOVE_KEY, 32'sh7fff_ffff, '0));
		send_command(cmd_of(CMD_REMOVE_KEY, 32'sh8000_0000, '0));
		send_command(cmd_of(CMD_REMOVE_HEAD, 32'sd0, '0));

		run_random(215);
		hold_requests++;
		run_random(215);
		drain_results();

		// phase two: roles swapped
		src_idle_pct  = 72;
		sink_idle_pct = 38;
		run_random(430);
		drain_results();

		// phase three: full rate both ways, with a long receiver hold-off midway
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_random(215);
		hold_requests++;
		run_random(215);
		drain_results();

		// anything the block still emits would show up as an unowed result
		repeat (SETTLE) @(posedge clk);
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/spq_scan.sv
hdl/sorted_priority_queue.sv
dv/sorted_priority_queue_test.sv
